/* hw/rtl/subband_dpcm_vq_pixel_decoder_top_macros.svh */
// ---------------------------------------------------------------------------
// sub-band dpcm vq pixel decoder: assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef SUBBAND_DPCM_VQ_PIXEL_DECODER_TOP_MACROS_SVH
`define SUBBAND_DPCM_VQ_PIXEL_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define SDVQ_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDVQ_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/sdvq_pkg.sv */
// ---------------------------------------------------------------------------
// sdvq_pkg
// types and constants shared by the sub-band dpcm vq pixel decoder
// ---------------------------------------------------------------------------
package sdvq_pkg;

  localparam int BYTE_W      = 8;
  localparam int ENTRY_W     = 7;
  localparam int TBL_W       = 3;
  localparam int ADDR_W      = TBL_W + ENTRY_W;
  localparam int TBL_COUNT   = 6;
  localparam int STORE_DEPTH = TBL_COUNT * (1 << ENTRY_W);
  localparam int K_W         = 4;
  localparam int CNT_W       = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_DATA  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 1'b1;

  localparam logic [TBL_W-1:0] HP_TABLE_BASE = 3'd3;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_DATA  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic       start;
    logic       rd;
    logic       high;
    logic [1:0] chan;
    logic       last;
  } rd_tag_t;

endpackage

/* hw/rtl/sdvq_ram.sv */
// ---------------------------------------------------------------------------
// sdvq_ram
// generic single-write, single-read memory with registered read data
// ---------------------------------------------------------------------------
module sdvq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 768,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/sdvq_front.sv */
// ---------------------------------------------------------------------------
// sdvq_front
// accepts input items, drops ignored ones and queues the rest for the back
// ---------------------------------------------------------------------------
module sdvq_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_operation,
  input  logic [sdvq_pkg::TBL_W-1:0]          in_table_select,
  input  logic [sdvq_pkg::ENTRY_W-1:0]        in_entry_index,
  input  logic [sdvq_pkg::BYTE_W-1:0]         in_value,
  output logic                                q_valid,
  output sdvq_pkg::item_t                     q_item,
  input  logic                                q_pop
);

  localparam int QD  = 2;
  localparam int QAW = $clog2(QD);
  localparam int QCW = $clog2(QD + 1);

  sdvq_pkg::item_t items_r [QD];
  sdvq_pkg::item_t item_in;
  logic [QAW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]  count_r, count_nxt;
  logic            keep;
  logic            push;
  logic            pop;

  always_comb begin
    keep         = 1'b0;
    item_in.kind = sdvq_pkg::KIND_DATA;
    unique case (in_operation)
      sdvq_pkg::OP_LOAD: begin
        keep         = (in_table_select < sdvq_pkg::TBL_W'(sdvq_pkg::TBL_COUNT));
        item_in.kind = sdvq_pkg::KIND_LOAD;
      end
      sdvq_pkg::OP_START: begin
        keep         = 1'b1;
        item_in.kind = sdvq_pkg::KIND_START;
      end
      sdvq_pkg::OP_DATA: begin
        keep         = 1'b1;
        item_in.kind = sdvq_pkg::KIND_DATA;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    item_in.addr  = {in_table_select, in_entry_index};
    item_in.value = in_value;
  end

  assign in_stall = (count_r == QCW'(QD));
  assign q_valid  = (count_r != '0);
  assign q_item   = items_r[rd_ptr_r];
  assign push     = in_valid && !in_stall && keep;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt  = count_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      items_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

/* hw/rtl/sdvq_engine.sv */
// ---------------------------------------------------------------------------
// sdvq_engine
// back-end sequencer: codebook loads, image start and bit-serial index
// unpacking; both codebook reads of a channel are made once its high-pass
// index completes, low-pass first, high-pass on the following cycle
// ---------------------------------------------------------------------------
module sdvq_engine #(
  parameter int MAX_INDEX_BITS = 7
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [sdvq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sdvq_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 q_valid,
  input  sdvq_pkg::item_t                      q_item,
  output logic                                 q_pop,
  input  logic                                 out_room,
  output logic                                 ram_wr_en,
  output logic [sdvq_pkg::ADDR_W-1:0]          ram_wr_addr,
  output logic [sdvq_pkg::BYTE_W-1:0]          ram_wr_data,
  output logic                                 ram_rd_en,
  output logic [sdvq_pkg::ADDR_W-1:0]          ram_rd_addr,
  output sdvq_pkg::rd_tag_t                    tag
);

  localparam int IDX_W = MAX_INDEX_BITS;
  localparam int CW    = sdvq_pkg::CNT_W;
  localparam int KW    = sdvq_pkg::K_W;

  logic [2:0]                     index_bits_r;
  logic [CW-1:0]                  pixel_count_r;

  logic [2:0]                     bit_cnt_r, bit_cnt_nxt;
  logic [IDX_W-1:0]               partial_r, partial_nxt;
  logic [2:0]                     taken_r, taken_nxt;
  logic [1:0]                     chan_r, chan_nxt;
  logic                           phase_r, phase_nxt;
  logic [sdvq_pkg::ENTRY_W-1:0]   held_r, held_nxt;
  logic [CW-1:0]                  pixels_done_r, pixels_done_nxt;
  sdvq_pkg::rd_tag_t              hp_tag_r, hp_tag_nxt;
  logic [sdvq_pkg::ADDR_W-1:0]    hp_addr_r, hp_addr_nxt;

  logic [KW-1:0]                  k_eff;
  logic [IDX_W-1:0]               mask;
  logic                           bit_val;
  logic [IDX_W-1:0]               partial_new;
  logic [2:0]                     taken_inc;
  logic                           idx_done;
  logic [IDX_W+sdvq_pkg::ENTRY_W-1:0] idx_wide;
  logic [sdvq_pkg::ENTRY_W-1:0]   entry;
  logic [sdvq_pkg::TBL_W-1:0]     tbl;
  logic                           img_done;
  logic                           is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_bits_r  <= 3'd1;
      pixel_count_r <= CW'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sdvq_pkg::CFG_INDEX_BITS:  index_bits_r  <= cfg_wdata[2:0];
        sdvq_pkg::CFG_PIXEL_COUNT: pixel_count_r <= cfg_wdata[CW-1:0];
      endcase
    end
  end

  always_comb begin
    priority if (index_bits_r == 3'd0) begin
      k_eff = KW'(1);
    end else if ({1'b0, index_bits_r} > KW'(MAX_INDEX_BITS)) begin
      k_eff = KW'(MAX_INDEX_BITS);
    end else begin
      k_eff = {1'b0, index_bits_r};
    end
    for (int i = 0; i < IDX_W; i++) begin
      mask[i] = (KW'(i) < k_eff);
    end
  end

  assign bit_val     = q_item.value[3'd7 - bit_cnt_r];
  assign partial_new = ((partial_r << 1) | IDX_W'(bit_val)) & mask;
  assign taken_inc   = taken_r + 3'd1;
  assign idx_done    = ({1'b0, taken_inc} >= k_eff);
  assign idx_wide    = {{sdvq_pkg::ENTRY_W{1'b0}}, partial_new};
  assign entry       = idx_wide[sdvq_pkg::ENTRY_W-1:0];
  assign tbl         = sdvq_pkg::HP_TABLE_BASE + {1'b0, chan_r};
  assign img_done    = (pixels_done_r >= pixel_count_r);
  assign is_last     = (CW'(pixels_done_r + CW'(1)) == pixel_count_r);

  assign ram_wr_addr = q_item.addr;
  assign ram_wr_data = q_item.value;

  always_comb begin
    bit_cnt_nxt     = bit_cnt_r;
    partial_nxt     = partial_r;
    taken_nxt       = taken_r;
    chan_nxt        = chan_r;
    phase_nxt       = phase_r;
    held_nxt        = held_r;
    pixels_done_nxt = pixels_done_r;
    hp_tag_nxt      = '0;
    hp_addr_nxt     = hp_addr_r;
    q_pop           = 1'b0;
    ram_wr_en       = 1'b0;
    // high-pass read left over from the previous cycle
    ram_rd_en       = hp_tag_r.rd;
    ram_rd_addr     = hp_addr_r;
    tag             = hp_tag_r;
    if (q_valid) begin
      unique case (q_item.kind)
        sdvq_pkg::KIND_LOAD: begin
          ram_wr_en = 1'b1;
          q_pop     = 1'b1;
        end
        sdvq_pkg::KIND_START: begin
          q_pop           = 1'b1;
          tag.start       = 1'b1;
          bit_cnt_nxt     = '0;
          partial_nxt     = '0;
          taken_nxt       = '0;
          chan_nxt        = '0;
          phase_nxt       = 1'b0;
          held_nxt        = '0;
          pixels_done_nxt = '0;
        end
        sdvq_pkg::KIND_DATA: begin
          if (img_done) begin
            q_pop       = 1'b1;
            bit_cnt_nxt = '0;
          end else if (out_room) begin
            bit_cnt_nxt = bit_cnt_r + 3'd1;
            q_pop       = (bit_cnt_r == 3'd7);
            if (idx_done) begin
              partial_nxt = '0;
              taken_nxt   = '0;
              if (!phase_r) begin
                held_nxt  = entry;
                phase_nxt = 1'b1;
              end else begin
                ram_rd_en       = 1'b1;
                ram_rd_addr     = {1'b0, chan_r, held_r};
                tag.rd          = 1'b1;
                tag.high        = 1'b0;
                tag.chan        = chan_r;
                tag.last        = 1'b0;
                hp_tag_nxt.rd   = 1'b1;
                hp_tag_nxt.high = 1'b1;
                hp_tag_nxt.chan = chan_r;
                hp_tag_nxt.last = is_last;
                hp_addr_nxt     = {tbl, entry};
                phase_nxt       = 1'b0;
                if (chan_r == 2'd2) begin
                  chan_nxt        = '0;
                  pixels_done_nxt = pixels_done_r + CW'(1);
                end else begin
                  chan_nxt = chan_r + 2'd1;
                end
              end
            end else begin
              partial_nxt = partial_new;
              taken_nxt   = taken_inc;
            end
          end
        end
        default: begin
          q_pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cnt_r     <= '0;
      partial_r     <= '0;
      taken_r       <= '0;
      chan_r        <= '0;
      phase_r       <= 1'b0;
      held_r        <= '0;
      pixels_done_r <= '0;
      hp_tag_r      <= '0;
      hp_addr_r     <= '0;
    end else begin
      bit_cnt_r     <= bit_cnt_nxt;
      partial_r     <= partial_nxt;
      taken_r       <= taken_nxt;
      chan_r        <= chan_nxt;
      phase_r       <= phase_nxt;
      held_r        <= held_nxt;
      pixels_done_r <= pixels_done_nxt;
      hp_tag_r      <= hp_tag_nxt;
      hp_addr_r     <= hp_addr_nxt;
    end
  end

endmodule

/* hw/rtl/sdvq_recon.sv */
// ---------------------------------------------------------------------------
// sdvq_recon
// dpcm reconstruction of each channel and the outgoing pixel queue
// ---------------------------------------------------------------------------
module sdvq_recon (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sdvq_pkg::rd_tag_t             tag,
  input  logic [sdvq_pkg::BYTE_W-1:0]   rd_data,
  output logic                          out_room,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sdvq_pkg::BYTE_W-1:0]   out_blue,
  output logic [sdvq_pkg::BYTE_W-1:0]   out_green,
  output logic [sdvq_pkg::BYTE_W-1:0]   out_red,
  output logic                          out_last_pixel
);

  localparam int BW  = sdvq_pkg::BYTE_W;
  localparam int OQD = 4;
  localparam int OAW = $clog2(OQD);
  localparam int OCW = $clog2(OQD + 1);
  localparam logic [BW-1:0] LP_START = 8'd128;
  localparam logic [BW-1:0] PIX_MAX  = 8'd255;

  typedef struct packed {
    logic [BW-1:0] blue;
    logic [BW-1:0] green;
    logic [BW-1:0] red;
    logic          last;
  } pixel_t;

  function automatic logic [BW-1:0] clamp_add(logic [BW-1:0] base, logic [BW-1:0] delta);
    logic signed [BW+1:0] sum;
    sum = signed'({2'b00, base}) + signed'({{2{delta[BW-1]}}, delta});
    if (sum < 0) begin
      return '0;
    end else if (sum > signed'({2'b00, PIX_MAX})) begin
      return PIX_MAX;
    end
    return sum[BW-1:0];
  endfunction

  sdvq_pkg::rd_tag_t tag_r;
  logic [BW-1:0]     held_lp_r, held_lp_nxt;
  logic [BW-1:0]     prev_r [3];
  logic [BW-1:0]     prev_nxt [3];
  logic [BW-1:0]     pend_r [2];
  logic [BW-1:0]     pend_nxt [2];
  logic [BW-1:0]     prev_sel;
  logic [BW-1:0]     lp_new;
  logic [BW-1:0]     pix;

  pixel_t            oq_r [OQD];
  pixel_t            pix_item;
  logic [OAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [OAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [OCW-1:0]    count_r, count_nxt;
  logic              push;
  logic              pop;

  always_comb begin
    unique case (tag_r.chan)
      2'd0:    prev_sel = prev_r[0];
      2'd1:    prev_sel = prev_r[1];
      default: prev_sel = prev_r[2];
    endcase
  end

  assign lp_new = clamp_add(prev_sel, rd_data);
  assign pix    = clamp_add(held_lp_r, rd_data);

  always_comb begin
    held_lp_nxt = held_lp_r;
    prev_nxt    = prev_r;
    pend_nxt    = pend_r;
    push        = 1'b0;
    pix_item    = '{blue: pend_r[0], green: pend_r[1], red: pix, last: tag_r.last};
    if (tag_r.rd && !tag_r.high) begin
      held_lp_nxt = lp_new;
    end
    if (tag_r.rd && tag_r.high) begin
      prev_nxt[tag_r.chan] = held_lp_r;
      if (tag_r.chan == 2'd2) begin
        push = 1'b1;
      end else begin
        pend_nxt[tag_r.chan[0]] = pix;
      end
    end
    if (tag_r.start) begin
      for (int i = 0; i < 3; i++) begin
        prev_nxt[i] = LP_START;
      end
    end
  end

  assign out_valid      = (count_r != '0);
  assign pop            = out_valid && !out_stall;
  assign out_room       = (count_r <= OCW'(OQD - 2));
  assign out_blue       = oq_r[rd_ptr_r].blue;
  assign out_green      = oq_r[rd_ptr_r].green;
  assign out_red        = oq_r[rd_ptr_r].red;
  assign out_last_pixel = oq_r[rd_ptr_r].last;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + OAW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + OAW'(1) : rd_ptr_r;
    count_nxt  = count_r + OCW'(push) - OCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r    <= '0;
      prev_r   <= '{LP_START, LP_START, LP_START};
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      tag_r    <= tag;
      prev_r   <= prev_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_lp_r <= held_lp_nxt;
    pend_r    <= pend_nxt;
    if (push) begin
      oq_r[wr_ptr_r] <= pix_item;
    end
  end

endmodule

/* hw/rtl/subband_dpcm_vq_pixel_decoder_top.sv */
// ---------------------------------------------------------------------------
// subband_dpcm_vq_pixel_decoder_top
// decodes packed codebook indices into clamped bgr pixels
// ---------------------------------------------------------------------------
// channel  handshake            payload
// in       in_valid / in_stall  operation, table_select, entry_index, value
// out      out_valid/out_stall  blue, green, red, last_pixel
// cfg      cfg_wr_en            cfg_index, cfg_wdata
//
// a data byte is unpacked one stream bit per cycle while the output has
// room, each completed high-pass index making two reads, low-pass then
// high-pass, of the single codebook ram port
// a load, a start or a byte after the image's last pixel skips the unpacker
// a pixel is offered once its red high-pass read has passed the engine's held
// read register, ram read register and output queue; 2-item input queue
// synchronous reset, codebook contents undefined until loaded, no clearing
// the unpacker pauses while fewer than two of four output slots are free
// ---------------------------------------------------------------------------
module subband_dpcm_vq_pixel_decoder_top #(
  parameter int MAX_INDEX_BITS = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_operation,
  input  logic [sdvq_pkg::TBL_W-1:0]          in_table_select,
  input  logic [sdvq_pkg::ENTRY_W-1:0]        in_entry_index,
  input  logic [sdvq_pkg::BYTE_W-1:0]         in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sdvq_pkg::BYTE_W-1:0]         out_blue,
  output logic [sdvq_pkg::BYTE_W-1:0]         out_green,
  output logic [sdvq_pkg::BYTE_W-1:0]         out_red,
  output logic                                out_last_pixel,
  input  logic                                cfg_wr_en,
  input  logic [sdvq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sdvq_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic                              q_valid;
  sdvq_pkg::item_t                   q_item;
  logic                              q_pop;
  logic                              out_room;
  logic                              ram_wr_en;
  logic [sdvq_pkg::ADDR_W-1:0]       ram_wr_addr;
  logic [sdvq_pkg::BYTE_W-1:0]       ram_wr_data;
  logic                              ram_rd_en;
  logic [sdvq_pkg::ADDR_W-1:0]       ram_rd_addr;
  logic [sdvq_pkg::BYTE_W-1:0]       ram_rd_data;
  sdvq_pkg::rd_tag_t                 tag;

  sdvq_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_table_select (in_table_select),
    .in_entry_index  (in_entry_index),
    .in_value        (in_value),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  sdvq_engine #(
    .MAX_INDEX_BITS (MAX_INDEX_BITS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_room    (out_room),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .tag         (tag)
  );

  sdvq_ram #(
    .WIDTH (sdvq_pkg::BYTE_W),
    .DEPTH (sdvq_pkg::STORE_DEPTH)
  ) u_codebook (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  sdvq_recon u_recon (
    .clk            (clk),
    .rst_n          (rst_n),
    .tag            (tag),
    .rd_data        (ram_rd_data),
    .out_room       (out_room),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_blue       (out_blue),
    .out_green      (out_green),
    .out_red        (out_red),
    .out_last_pixel (out_last_pixel)
  );

endmodule

/* hw/rtl/sdvq_checker.sv */
// ---------------------------------------------------------------------------
// sdvq_checker
// port-level checks on the decoder top, attached by bind
// ---------------------------------------------------------------------------
`include "subband_dpcm_vq_pixel_decoder_top_macros.svh"

module sdvq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [sdvq_pkg::BYTE_W-1:0]   out_blue,
  input logic [sdvq_pkg::BYTE_W-1:0]   out_green,
  input logic [sdvq_pkg::BYTE_W-1:0]   out_red,
  input logic                          out_last_pixel
);

  `SDVQ_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && out_stall, out_valid, "out item dropped while stalled")

  `SDVQ_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_blue) && $stable(out_green) && $stable(out_red) && $stable(out_last_pixel), "out item changed while stalled")

  `SDVQ_ASSERT_SAME(a_reset_empty, clk, rst_n, $rose(rst_n), !out_valid && !in_stall, "queues not empty after reset")

  `SDVQ_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, $past(in_stall) || $past(in_valid && !in_stall), "input stall without a prior item")

endmodule

bind subband_dpcm_vq_pixel_decoder_top sdvq_checker u_sdvq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_blue       (out_blue),
  .out_green      (out_green),
  .out_red        (out_red),
  .out_last_pixel (out_last_pixel)
);
